@@ rtl/rmrx_pkg.sv @@
package rmrx_pkg;

  // Line store depth and the counter width that can hold it
  localparam int LINE_BUF_DEPTH = 32;
  localparam int LEN_W          = $clog2(LINE_BUF_DEPTH + 1);

  // Line length at which a ':' opens a data packet, and the comma positions
  localparam int MARK_LEN    = 10;
  localparam int COMMA_POS_A = 2;
  localparam int COMMA_POS_B = 7;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_N     = 8'h4e;
  localparam logic [7:0] CH_G     = 8'h47;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_DATA  = 3'd1,
    EV_END   = 3'd2,
    EV_OK    = 3'd3,
    EV_NG    = 3'd4,
    EV_OTHER = 3'd5
  } event_t;

  // Hex pair decoder phase
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  // One result item
  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
  } result_t;

endpackage

@@ rtl/rmrx_parse.sv @@
module rmrx_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  output rmrx_pkg::result_t result
);
  import rmrx_pkg::*;

  // Only positions 0, 1, 2 and 7 of the line are ever examined, so only
  // those characters are kept; the rest of the line is counted, not stored.
  logic             in_data_mode, in_data_mode_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic [7:0]       store0, store1, store2, store7;
  phase_t           digit_phase, digit_phase_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             store_wr;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  logic is_eol, is_end, enter_data, line_full;

  assign is_eol     = (ch == CH_NUL) || (ch == CH_LF) || (ch == CH_CR);
  assign is_end     = (ch == CH_LF) || (ch == CH_CR);
  assign line_full  = (line_length >= LEN_W'(LINE_BUF_DEPTH));
  assign enter_data = (ch == CH_COLON) && (line_length == LEN_W'(MARK_LEN)) &&
                      (store2 == CH_COMMA) && (store7 == CH_COMMA);

  // Work out the result and the next state for the current character
  always_comb begin
    in_data_mode_next = in_data_mode;
    line_length_next  = line_length;
    digit_phase_next  = digit_phase;
    high_nibble_next  = high_nibble;
    store_wr          = 1'b0;
    result.ev         = EV_NONE;
    result.data       = 8'd0;
    if (!in_data_mode) begin
      if (is_eol) begin
        result.ev = EV_OTHER;
        if (line_length >= LEN_W'(2)) begin
          if (store0 == CH_O && store1 == CH_K) result.ev = EV_OK;
          else if (store0 == CH_N && store1 == CH_G) result.ev = EV_NG;
        end
        line_length_next = '0;
      end else if (enter_data) begin
        in_data_mode_next = 1'b1;
        digit_phase_next  = PH_HIGH;
      end else if (!line_full) begin
        store_wr         = 1'b1;
        line_length_next = line_length + LEN_W'(1);
      end
    end else begin
      if (is_end) begin
        result.ev         = EV_END;
        in_data_mode_next = 1'b0;
        line_length_next  = '0;
      end else begin
        case (digit_phase)
          PH_HIGH: begin
            high_nibble_next = hex_value(ch);
            digit_phase_next = PH_LOW;
          end
          PH_LOW: begin
            result.ev        = EV_DATA;
            result.data      = {high_nibble, hex_value(ch)};
            digit_phase_next = PH_SKIP;
          end
          default: begin
            if (ch == CH_COMMA) digit_phase_next = PH_HIGH;
          end
        endcase
      end
    end
  end

  // Advance the parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_mode <= 1'b0;
      line_length  <= '0;
      digit_phase  <= PH_HIGH;
      high_nibble  <= 4'd0;
    end else if (step) begin
      in_data_mode <= in_data_mode_next;
      line_length  <= line_length_next;
      digit_phase  <= digit_phase_next;
      high_nibble  <= high_nibble_next;
    end
  end

  // Capture the characters at the examined line positions
  always_ff @(posedge clk) begin
    if (step && store_wr) begin
      if (line_length == LEN_W'(0)) store0 <= ch;
      if (line_length == LEN_W'(1)) store1 <= ch;
      if (line_length == LEN_W'(COMMA_POS_A)) store2 <= ch;
      if (line_length == LEN_W'(COMMA_POS_B)) store7 <= ch;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_BUF_DEPTH))
    else $error("line length beyond store depth");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    $rose(in_data_mode) |-> line_length == LEN_W'(MARK_LEN) && digit_phase == PH_HIGH)
    else $error("data mode entered without a qualifying header");

  a_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(in_data_mode) |-> line_length == LEN_W'(0))
    else $error("line length not cleared at packet end");

  a_data_mode: assert property (@(posedge clk) disable iff (rst)
    (result.ev == EV_DATA || result.ev == EV_END) |-> in_data_mode)
    else $error("data event outside data mode");
`endif

endmodule

@@ rtl/radio_module_rx_line_parser.sv @@
// Channel   Dir   Signals                       Content
// s_*       in    s_tvalid s_tready s_tdata     [7:0] rx_char
// m_*       out   m_tvalid m_tready m_tdata     [2:0] event_res, [10:3] data_byte
//
// One character is taken per cycle while the result register is not stalled; each
// character's result passes through the input register, then the result register,
// and is held there until it is taken.
// Parser state advances once per character, in a single combinational pass.
// rst is synchronous and returns the parser to command mode with an empty line.
// A stalled result register holds the input register; input takes a new character
// whenever the input register is empty or the result register is empty or being emptied.
module radio_module_rx_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] event_res, [10:3] data_byte, [15:11] zero
);
  import rmrx_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       advance;
  result_t    result;
  result_t    out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  rmrx_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .ch     (in_char),
    .result (result)
  );

  // Hold the accepted character until it moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_char <= s_tdata;
  end

  // Result register: load on advance, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= result;
  end

  assign m_tdata = {5'd0, out_res.data, out_res.ev};

endmodule

@@ sim/tb_radio_module_rx_line_parser.sv @@
`timescale 1ns / 1ps

module tb_radio_module_rx_line_parser;
  import rmrx_pkg::*;

  // Cycles with work pending but no transfer on either side before giving up
  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_HALF = 75;
  localparam int NUM_PHASES     = 4;

  // One character to send, with an optional hand-typed expectation
  typedef struct {
    logic [7:0] ch;
    bit         fixed;
    event_t     ev;
    logic [7:0] data;
  } rx_item_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // Stimulus and expected results
  rx_item_t directed_rows[$];
  rx_item_t rx_chars[$];
  result_t  pending_results[$];

  // Parser mirror
  bit           dm_active = 1'b0;
  logic [LEN_W-1:0] line_len = '0;
  logic [7:0]   line_buf [LINE_BUF_DEPTH];
  phase_t       hex_phase = PH_HIGH;
  logic [3:0]   hex_hi = 4'h0;

  // Run bookkeeping
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  s_taken        = 1'b0;
  int  idle_cycles    = 0;
  int  gen_count      = 0;
  int  fail_count     = 0;
  int  chars_sent     = 0;
  int  results_seen   = 0;
  int  packets_built  = 0;
  int  ev_seen [8];

  radio_module_rx_line_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hex digit value; anything else reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
    return 4'h0;
  endfunction

  // Advance the parser mirror by one character and give its result
  task automatic parse_char(input logic [7:0] c, output result_t r);
    r.ev   = EV_NONE;
    r.data = 8'h00;
    if (!dm_active) begin
      if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
        r.ev = EV_OTHER;
        if (line_len >= 2 && line_buf[0] == CH_O && line_buf[1] == CH_K)
          r.ev = EV_OK;
        else if (line_len >= 2 && line_buf[0] == CH_N && line_buf[1] == CH_G)
          r.ev = EV_NG;
        line_len = '0;
      end else if (c == CH_COLON && line_len == MARK_LEN &&
                   line_buf[COMMA_POS_A] == CH_COMMA &&
                   line_buf[COMMA_POS_B] == CH_COMMA) begin
        dm_active = 1'b1;
        hex_phase = PH_HIGH;
      end else if (line_len < LINE_BUF_DEPTH) begin
        line_buf[line_len] = c;
        line_len = line_len + 1'b1;
      end
    end else begin
      if (c == CH_CR || c == CH_LF) begin
        r.ev      = EV_END;
        dm_active = 1'b0;
        line_len  = '0;
      end else begin
        case (hex_phase)
          PH_HIGH: begin
            hex_hi    = hex_nibble(c);
            hex_phase = PH_LOW;
          end
          PH_LOW: begin
            r.ev      = EV_DATA;
            r.data    = {hex_hi, hex_nibble(c)};
            hex_phase = PH_SKIP;
          end
          default: begin
            if (c == CH_COMMA) hex_phase = PH_HIGH;
          end
        endcase
      end
    end
  endtask

  // Directed table entry
  task automatic row(input logic [7:0] c, input bit fixed, input event_t ev,
                     input logic [7:0] data);
    rx_item_t it;
    it.ch    = c;
    it.fixed = fixed;
    it.ev    = ev;
    it.data  = data;
    directed_rows.push_back(it);
  endtask

  task automatic push_char(input logic [7:0] c);
    rx_item_t it;
    it.ch    = c;
    it.fixed = 1'b0;
    it.ev    = EV_NONE;
    it.data  = 8'h00;
    rx_chars.push_back(it);
    gen_count++;
  endtask

  // Any byte that does not end a packet
  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // Any byte that does not end a line
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = payload_char(); while (c == CH_NUL);
    return c;
  endfunction

  // Mostly hex digits of either case, sometimes junk
  function automatic logic [7:0] digit_char();
    int v;
    if ($urandom_range(7) == 0) return payload_char();
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 16) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 16);
  endfunction

  function automatic logic [7:0] line_end();
    case ($urandom_range(0, 2))
      0:       return CH_NUL;
      1:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Header, colon, hex pairs with skipped tails and commas, then CR or LF
  task automatic gen_packet();
    int pairs;
    bit cut;
    pairs = $urandom_range(1, 8);
    cut   = 1'b0;
    for (int i = 0; i < MARK_LEN; i++)
      push_char((i == COMMA_POS_A || i == COMMA_POS_B) ? CH_COMMA : text_char());
    push_char(CH_COLON);
    for (int p = 0; p < pairs && !cut; p++) begin
      push_char(digit_char());
      // end some packets in the middle of a pair
      if ($urandom_range(9) == 0) begin
        cut = 1'b1;
      end else begin
        push_char(digit_char());
        repeat ($urandom_range(0, 3)) push_char(payload_char());
        if (p != pairs - 1) push_char(CH_COMMA);
      end
    end
    push_char($urandom_range(1) ? CH_CR : CH_LF);
    packets_built++;
  endtask

  // Command-mode replies: ok, ng, short, near misses, overlong, plain text
  task automatic gen_cmd_line();
    case ($urandom_range(0, 5))
      0: begin
        push_char(CH_O);
        push_char(CH_K);
        repeat ($urandom_range(0, 6)) push_char(text_char());
      end
      1: begin
        push_char(CH_N);
        push_char(CH_G);
        repeat ($urandom_range(0, 6)) push_char(text_char());
      end
      2: repeat ($urandom_range(0, 1)) push_char(text_char());
      3: begin
        push_char($urandom_range(1) ? CH_O : CH_N);
        repeat ($urandom_range(1, 4)) push_char(text_char());
      end
      4: begin
        // fill the store, then a colon that must be dropped
        repeat ($urandom_range(LINE_BUF_DEPTH, LINE_BUF_DEPTH + 8)) push_char(text_char());
        push_char(CH_COLON);
      end
      default: repeat ($urandom_range(2, 12)) push_char(text_char());
    endcase
    push_char(line_end());
    if ($urandom_range(3) == 0) push_char(CH_LF);
  endtask

  // Header that misses: a comma missing or the colon at the wrong length
  task automatic gen_bad_header();
    int kind;
    int len;
    logic [7:0] c;
    kind = $urandom_range(0, 3);
    len  = (kind == 2) ? MARK_LEN - 1 : (kind == 3) ? MARK_LEN + 1 : MARK_LEN;
    for (int i = 0; i < len; i++) begin
      c = text_char();
      if ((i == COMMA_POS_A && kind != 0) || (i == COMMA_POS_B && kind != 1))
        c = CH_COMMA;
      else if (c == CH_COMMA)
        c = 8'h78;
      push_char(c);
    end
    push_char(CH_COLON);
    repeat ($urandom_range(0, 4)) push_char(text_char());
    push_char(line_end());
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
    if ($urandom_range(1)) push_char(line_end());
  endtask

  // Drive inputs on the falling edge; hold a pending transfer until taken
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (rx_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= rx_chars[0].ch;
      end else begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Sample both sides on the rising edge; predict and check
  always @(posedge clk) begin : monitor
    result_t calc;
    result_t want;
    bit      m_taken;
    s_taken = 1'b0;
    m_taken = 1'b0;
    if (!rst) begin
      // input transfer: run the mirror, prefer a typed expectation
      if (s_tvalid && s_tready) begin
        s_taken = 1'b1;
        parse_char(rx_chars[0].ch, calc);
        if (rx_chars[0].fixed) begin
          calc.ev   = rx_chars[0].ev;
          calc.data = rx_chars[0].data;
        end
        pending_results.push_back(calc);
        rx_chars.delete(0);
        chars_sent++;
      end
      // output transfer: compare with the oldest expectation
      if (m_tvalid && m_tready) begin
        m_taken = 1'b1;
        results_seen++;
        ev_seen[m_tdata[2:0]]++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: event_res %0d data_byte %02h",
                 m_tdata[2:0], m_tdata[10:3]);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[2:0] !== want.ev) begin
            $error("event_res: expected %0d, actual %0d", want.ev, m_tdata[2:0]);
            fail_count++;
          end
          if (m_tdata[10:3] !== want.data) begin
            $error("data_byte: expected %02h, actual %02h", want.data, m_tdata[10:3]);
            fail_count++;
          end
          if (m_tdata[15:11] !== 5'd0) begin
            $error("pad: expected 0, actual %0h", m_tdata[15:11]);
            fail_count++;
          end
        end
      end
      // count cycles where work waits and nothing moves
      if (s_taken || m_taken || (rx_chars.size() == 0 && pending_results.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $error("no transfer for %0d cycles with work pending", STALL_LIMIT);
    $display("tb_radio_module_rx_line_parser: FAIL");
    $finish;
  end

  // Phases of idling: none, sender, receiver, both
  initial begin : stimulus
    int idle_mix [NUM_PHASES];
    int stall_mix [NUM_PHASES];
    int pick;
    idle_mix  = '{0, 75, 0, 27};
    stall_mix = '{0, 0, 75, 27};
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    foreach (ev_seen[i]) ev_seen[i] = 0;

    // Directed: empty line after reset, ok ended by NUL and ng ended by LF, a packet
    // with extreme bytes, a skipped tail, junk and NUL as digits, then LF
    row(CH_CR,    1'b1, EV_OTHER, 8'h00);
    row(CH_O,     1'b0, EV_NONE,  8'h00);
    row(CH_K,     1'b0, EV_NONE,  8'h00);
    row(CH_NUL,   1'b1, EV_OK,    8'h00);
    row(CH_N,     1'b0, EV_NONE,  8'h00);
    row(CH_G,     1'b0, EV_NONE,  8'h00);
    row(CH_LF,    1'b1, EV_NG,    8'h00);
    row(8'hff,    1'b0, EV_NONE,  8'h00);
    row(8'h61,    1'b0, EV_NONE,  8'h00);
    row(CH_COMMA, 1'b0, EV_NONE,  8'h00);
    row(8'h31,    1'b0, EV_NONE,  8'h00);
    row(8'h32,    1'b0, EV_NONE,  8'h00);
    row(8'h33,    1'b0, EV_NONE,  8'h00);
    row(8'h34,    1'b0, EV_NONE,  8'h00);
    row(CH_COMMA, 1'b0, EV_NONE,  8'h00);
    row(8'h35,    1'b0, EV_NONE,  8'h00);
    row(8'h36,    1'b0, EV_NONE,  8'h00);
    row(CH_COLON, 1'b0, EV_NONE,  8'h00);
    row(8'h66,    1'b0, EV_NONE,  8'h00);
    row(8'h46,    1'b1, EV_DATA,  8'hff);
    row(8'h7a,    1'b0, EV_NONE,  8'h00);
    row(CH_COMMA, 1'b0, EV_NONE,  8'h00);
    row(8'h67,    1'b0, EV_NONE,  8'h00);
    row(CH_NUL,   1'b1, EV_DATA,  8'h00);
    row(CH_LF,    1'b1, EV_END,   8'h00);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      if (ph == 0)
        foreach (directed_rows[i]) rx_chars.push_back(directed_rows[i]);
      // two halves; the sender waits for every result between them
      for (int half = 0; half < 2; half++) begin
        gen_count = 0;
        while (gen_count < ITEMS_PER_HALF) begin
          pick = $urandom_range(99);
          if (pick < 45)      gen_packet();
          else if (pick < 75) gen_cmd_line();
          else if (pick < 90) gen_bad_header();
          else                gen_noise();
        end
        while (rx_chars.size() != 0 || pending_results.size() != 0) @(negedge clk);
      end
    end

    // let any stray result show up
    repeat (10) @(negedge clk);

    $display("Sent %0d characters (%0d packets built) under four idle/stall mixes.",
             chars_sent, packets_built);
    $display("Results: %0d data, %0d packet ends, %0d ok, %0d ng, %0d other, %0d none.",
             ev_seen[EV_DATA], ev_seen[EV_END], ev_seen[EV_OK], ev_seen[EV_NG],
             ev_seen[EV_OTHER], ev_seen[EV_NONE]);
    if (fail_count == 0) begin
      $display("tb_radio_module_rx_line_parser: PASS");
    end else begin
      $display("tb_radio_module_rx_line_parser: FAIL");
    end
    $finish;
  end

endmodule
